// File: rtl/isst_pkg.sv
// shared types and constants for the indexed sequential sorted table
// used by isst_ctrl, isst_dp, the top level and the checker; no dependencies
package isst_pkg;

  // store geometry
  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int KEY_W  = 32;
  localparam int WIN_W  = 9;
  localparam int CUR_W  = WIN_W + 1;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

  // operation codes
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_IDX_RD,
    S_IDX_CMP,
    S_POST,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UP_RD,
    S_UP_WR,
    S_KEY_WR,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       idx_rd;
    logic       idx_step;
    logic       scan_init;
    logic       scan_rd;
    logic       scan_step;
    logic       up_init;
    logic       up_rd;
    logic       up_wr;
    logic       key_wr;
    logic       dn_init;
    logic       dn_rd;
    logic       dn_wr;
    logic       dec_count;
    logic       finish;
    logic [1:0] res;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic full;
    logic cnt_zero;
    logic idx_more;
    logic idx_pass;
    logic scan_more;
    logic scan_stop;
    logic up_more;
    logic dn_more;
  } sts_t;

endpackage

// File: rtl/isst_ctrl.sv
// controller state machine for the indexed sequential sorted table
// depends on isst_pkg for the state enum and the command and status structs
module isst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  isst_pkg::sts_t sts,
  output isst_pkg::cmd_t cmd
);

  isst_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != isst_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res   = isst_pkg::RES_OK;
    case (state_r)
      isst_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = isst_pkg::S_IDX_RD;
        end
      end
      // walk the primary index, one window head at a time
      isst_pkg::S_IDX_RD: begin
        if (sts.idx_more) begin
          cmd.idx_rd = 1'b1;
          state_nxt  = isst_pkg::S_IDX_CMP;
        end else begin
          state_nxt = isst_pkg::S_POST;
        end
      end
      isst_pkg::S_IDX_CMP: begin
        cmd.idx_step = 1'b1;
        state_nxt    = sts.idx_pass ? isst_pkg::S_IDX_RD : isst_pkg::S_POST;
      end
      // decide on the window result
      isst_pkg::S_POST: begin
        if (sts.is_ins) begin
          if (sts.full) begin
            cmd.finish = 1'b1;
            cmd.res    = isst_pkg::RES_FULL;
            state_nxt  = isst_pkg::S_IDLE;
          end else if (sts.cnt_zero) begin
            cmd.up_init = 1'b1;
            state_nxt   = isst_pkg::S_UP_RD;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = isst_pkg::S_SCAN_RD;
          end
        end else if (sts.cnt_zero) begin
          cmd.finish = 1'b1;
          cmd.res    = isst_pkg::RES_MISS;
          state_nxt  = isst_pkg::S_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = isst_pkg::S_SCAN_RD;
        end
      end
      // scan the chosen window
      isst_pkg::S_SCAN_RD: begin
        if (sts.scan_more) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = isst_pkg::S_SCAN_CMP;
        end else if (sts.is_ins) begin
          cmd.up_init = 1'b1;
          state_nxt   = isst_pkg::S_UP_RD;
        end else begin
          cmd.finish = 1'b1;
          cmd.res    = isst_pkg::RES_MISS;
          state_nxt  = isst_pkg::S_IDLE;
        end
      end
      isst_pkg::S_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_stop) begin
          if (sts.is_ins) begin
            cmd.up_init = 1'b1;
            state_nxt   = isst_pkg::S_UP_RD;
          end else if (sts.is_del) begin
            cmd.dn_init = 1'b1;
            state_nxt   = isst_pkg::S_DN_RD;
          end else begin
            cmd.finish = 1'b1;
            cmd.res    = isst_pkg::RES_OK;
            state_nxt  = isst_pkg::S_IDLE;
          end
        end else begin
          state_nxt = isst_pkg::S_SCAN_RD;
        end
      end
      // open a gap for the insert, top entry first
      isst_pkg::S_UP_RD: begin
        if (sts.up_more) begin
          cmd.up_rd = 1'b1;
          state_nxt = isst_pkg::S_UP_WR;
        end else begin
          state_nxt = isst_pkg::S_KEY_WR;
        end
      end
      isst_pkg::S_UP_WR: begin
        cmd.up_wr = 1'b1;
        state_nxt = isst_pkg::S_UP_RD;
      end
      isst_pkg::S_KEY_WR: begin
        cmd.key_wr = 1'b1;
        state_nxt  = isst_pkg::S_DONE;
      end
      // close the gap left by a delete
      isst_pkg::S_DN_RD: begin
        if (sts.dn_more) begin
          cmd.dn_rd = 1'b1;
          state_nxt = isst_pkg::S_DN_WR;
        end else begin
          cmd.dec_count = 1'b1;
          state_nxt     = isst_pkg::S_DONE;
        end
      end
      isst_pkg::S_DN_WR: begin
        cmd.dn_wr = 1'b1;
        state_nxt = isst_pkg::S_DN_RD;
      end
      isst_pkg::S_DONE: begin
        cmd.finish = 1'b1;
        cmd.res    = isst_pkg::RES_OK;
        state_nxt  = isst_pkg::S_IDLE;
      end
      default: begin
        state_nxt = isst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/isst_dp.sv
// datapath of the indexed sequential sorted table: entry memory, cursors,
// window size register and result registers; depends on isst_pkg
module isst_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  isst_pkg::cmd_t                     cmd,
  output isst_pkg::sts_t                     sts,
  input  logic [1:0]                        in_mode,
  input  logic signed [isst_pkg::KEY_W-1:0] in_key_value,
  input  logic                              cfg_wr,
  input  logic [isst_pkg::WIN_W-1:0]        cfg_window_size,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic                              out_found,
  output logic [isst_pkg::ADDR_W-1:0]       out_position,
  output logic signed [isst_pkg::WIN_W-1:0] out_window_index,
  output logic [isst_pkg::CNT_W-1:0]        out_entry_total
);

  localparam int AW = isst_pkg::ADDR_W;
  localparam int CW = isst_pkg::CNT_W;
  localparam int KW = isst_pkg::KEY_W;
  localparam int WW = isst_pkg::WIN_W;
  localparam int UW = isst_pkg::CUR_W;

  // entry store
  logic signed [KW-1:0] mem [isst_pkg::DEPTH];
  logic signed [KW-1:0] rd_data_r;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic signed [KW-1:0] wr_data;

  // working registers
  logic [1:0]           mode_r;
  logic signed [KW-1:0] key_r;
  logic [UW-1:0]        a_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        base_r;
  logic [CW-1:0]        j_r;
  logic [CW-1:0]        s_r;
  logic [CW-1:0]        k_r;
  logic [CW-1:0]        count_r;
  logic [WW-1:0]        window_r;
  logic [WW-1:0]        w_eff;
  logic                 key_lt;

  // result registers
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic                 out_found_r;
  logic [AW-1:0]        out_position_r;
  logic [WW-1:0]        out_window_index_r;
  logic [CW-1:0]        out_entry_total_r;

  // a window size of zero acts as one
  assign w_eff  = (window_r == '0) ? WW'(1) : window_r;
  assign key_lt = (key_r < rd_data_r);

  // status to the controller
  always_comb begin
    sts.is_ins    = (mode_r == isst_pkg::MODE_INSERT);
    sts.is_del    = (mode_r == isst_pkg::MODE_DELETE);
    sts.full      = (count_r == CW'(isst_pkg::DEPTH));
    sts.cnt_zero  = (cnt_r == '0);
    sts.idx_more  = (a_r < UW'(count_r));
    sts.idx_pass  = !key_lt;
    sts.scan_more = (UW'(j_r) < UW'(w_eff)) && (s_r < count_r);
    sts.scan_stop = (mode_r == isst_pkg::MODE_INSERT) ? key_lt : (rd_data_r == key_r);
    sts.up_more   = (k_r > s_r);
    sts.dn_more   = ((k_r + CW'(1)) < count_r);
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_r;
    if (cmd.idx_rd) begin
      rd_en   = 1'b1;
      rd_addr = a_r[AW-1:0];
    end else if (cmd.scan_rd) begin
      rd_en   = 1'b1;
      rd_addr = s_r[AW-1:0];
    end else if (cmd.up_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(k_r - CW'(1));
    end else if (cmd.dn_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(k_r + CW'(1));
    end
    if (cmd.up_wr || cmd.dn_wr) begin
      wr_en   = 1'b1;
      wr_addr = k_r[AW-1:0];
    end else if (cmd.key_wr) begin
      wr_en   = 1'b1;
      wr_addr = s_r[AW-1:0];
      wr_data = key_r;
    end
  end

  // single read and single write port, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // cursors and operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_key_value;
      a_r    <= '0;
      cnt_r  <= '0;
      base_r <= '0;
      s_r    <= '0;
    end
    if (cmd.idx_step && !key_lt) begin
      cnt_r  <= cnt_r + CW'(1);
      base_r <= a_r[CW-1:0];
      a_r    <= a_r + UW'(w_eff);
    end
    if (cmd.scan_init) begin
      s_r <= base_r;
      j_r <= '0;
    end
    if (cmd.scan_step && !sts.scan_stop) begin
      s_r <= s_r + CW'(1);
      j_r <= j_r + CW'(1);
    end
    if (cmd.up_init) begin
      k_r <= count_r;
    end
    if (cmd.dn_init) begin
      k_r <= s_r;
    end
    if (cmd.up_wr) begin
      k_r <= k_r - CW'(1);
    end
    if (cmd.dn_wr) begin
      k_r <= k_r + CW'(1);
    end
  end

  // entry count and window size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      window_r <= isst_pkg::WIN_RESET;
    end else begin
      if (cfg_wr) begin
        window_r <= cfg_window_size;
      end
      if (cmd.key_wr) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r       <= cmd.res;
      out_found_r        <= (cmd.res == isst_pkg::RES_OK);
      out_position_r     <= (cmd.res == isst_pkg::RES_OK) ? s_r[AW-1:0] : '0;
      out_window_index_r <= WW'(cnt_r - CW'(1));
      out_entry_total_r  <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_position     = out_position_r;
  assign out_window_index = $signed(out_window_index_r);
  assign out_entry_total  = out_entry_total_r;

endmodule

// File: rtl/indexed_sequential_sorted_table_core.sv
// top level of the indexed sequential sorted table
// instantiates isst_ctrl and isst_dp; depends on isst_pkg
//
// Sorted store of up to 256 signed 32-bit values with a sparse index of one
// head per window of cfg_window_size slots (0 acts as 1).
// Command channel: an operation (in_mode: search, insert, delete) and
// in_key_value are taken at a rising edge with start high and busy low.
// Result channel: out_valid pulses for one cycle with status, found flag,
// slot, chosen index entry and entry total; the receiver cannot stall it,
// and the next command may be taken in the same cycle as that pulse.
// Configuration: cfg_window_size is written on cfg_valid with cfg_ready,
// and cfg_ready is high while the block is idle.
// Each command walks the index heads (count / window size of them), scans
// the chosen window and, for an insert that goes in or a delete that
// succeeds, shifts the entries above the slot. Each read uses the
// registered read data of the entry memory, which has a single read port
// and a single write port.
// One command is in flight at a time. Reset empties the store, sets the
// window size to 4 and needs no clearing pass.
module indexed_sequential_sorted_table_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic signed [isst_pkg::KEY_W-1:0] in_key_value,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic                              out_found,
  output logic [isst_pkg::ADDR_W-1:0]       out_position,
  output logic signed [isst_pkg::WIN_W-1:0] out_window_index,
  output logic [isst_pkg::CNT_W-1:0]        out_entry_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [isst_pkg::WIN_W-1:0]        cfg_window_size
);

  isst_pkg::cmd_t cmd;
  isst_pkg::sts_t sts;

  // configuration beat taken while idle
  assign cfg_ready = !busy;

  isst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  isst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_key_value     (in_key_value),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_window_size  (cfg_window_size),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_position     (out_position),
    .out_window_index (out_window_index),
    .out_entry_total  (out_entry_total)
  );

endmodule

// File: rtl/isst_chk.sv
// port-level checker for the indexed sequential sorted table, with its bind
// depends on isst_pkg for the status codes
module isst_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [1:0]                        out_status,
  input logic                              out_found,
  input logic [isst_pkg::ADDR_W-1:0]       out_position,
  input logic [isst_pkg::CNT_W-1:0]        out_entry_total
);

  // an accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // a result beat comes as the block returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // result beats are single pulses
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a failed operation reports no slot and no hit
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != isst_pkg::RES_OK) |-> !out_found && (out_position == '0))
    else $error("failed operation reports a slot");

  // entry total never exceeds the store depth
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_total <= isst_pkg::CNT_W'(isst_pkg::DEPTH)))
    else $error("entry total beyond store depth");

endmodule

bind indexed_sequential_sorted_table_core isst_chk u_isst_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_position    (out_position),
  .out_entry_total (out_entry_total)
);

// File: sim/sorted_table_checker.sv
// result checker for the indexed sequential sorted table core
// watches the command, result and window-size channels; depends on isst_pkg
module sorted_table_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic signed [isst_pkg::KEY_W-1:0] in_key_value,
  input  logic                              out_valid,
  input  logic [1:0]                        out_status,
  input  logic                              out_found,
  input  logic [isst_pkg::ADDR_W-1:0]       out_position,
  input  logic signed [isst_pkg::WIN_W-1:0] out_window_index,
  input  logic [isst_pkg::CNT_W-1:0]        out_entry_total,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [isst_pkg::WIN_W-1:0]        cfg_window_size,
  output int                                pending,
  output int                                fail_count,
  output int                                results_seen,
  output int                                misses_seen,
  output int                                rejects_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;
  localparam int KEY_W  = isst_pkg::KEY_W;
  localparam int ADDR_W = isst_pkg::ADDR_W;
  localparam int CNT_W  = isst_pkg::CNT_W;
  localparam int WIN_W  = isst_pkg::WIN_W;

  typedef struct packed {
    logic [1:0]              status;
    logic                    found;
    logic [ADDR_W-1:0]       position;
    logic signed [WIN_W-1:0] window_index;
    logic [CNT_W-1:0]        entry_total;
  } table_result_t;

  // shadow copy of the store and the window register
  logic signed [KEY_W-1:0] shadow_entries [isst_pkg::DEPTH];
  int                      shadow_count;
  logic [WIN_W-1:0]        shadow_window;

  table_result_t awaited_results [$];
  int mismatches;
  int n_results;
  int n_misses;
  int n_rejects;

  initial begin
    pending      = 0;
    fail_count   = 0;
    results_seen = 0;
    misses_seen  = 0;
    rejects_seen = 0;
    mismatches   = 0;
    n_results    = 0;
    n_misses     = 0;
    n_rejects    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one command against the shadow store, returns the result it should give
  function automatic table_result_t predict_table_op(input logic [1:0] mode,
                                                     input logic signed [KEY_W-1:0] key);
    table_result_t r;
    int span;
    int head_total;
    int heads;
    int base;
    int j;
    int k;
    int slot;
    bit hit;
    r = '0;
    span = (shadow_window == '0) ? 1 : int'(shadow_window);
    head_total = (shadow_count + span - 1) / span;
    // last window whose head is not above the key
    heads = 0;
    while (heads < head_total && !(key < shadow_entries[heads * span]))
      heads++;
    r.window_index = WIN_W'(heads - 1);
    base = (heads - 1) * span;
    slot = 0;
    if (mode == isst_pkg::MODE_INSERT) begin
      if (shadow_count >= isst_pkg::DEPTH) begin
        r.status = isst_pkg::RES_FULL;
      end else begin
        // after every equal or smaller entry of the window
        if (heads > 0) begin
          j = 0;
          while (j < span && base + j < shadow_count && !(key < shadow_entries[base + j]))
            j++;
          slot = base + j;
        end
        for (k = shadow_count; k > slot; k--)
          shadow_entries[k] = shadow_entries[k - 1];
        shadow_entries[slot] = key;
        shadow_count++;
        r.status   = isst_pkg::RES_OK;
        r.found    = 1'b1;
        r.position = ADDR_W'(slot);
      end
    end else begin
      // search, delete and the spare code: first equal entry of the window
      hit = 1'b0;
      if (heads > 0) begin
        for (j = 0; j < span && base + j < shadow_count && !hit; j++) begin
          if (shadow_entries[base + j] == key) begin
            hit  = 1'b1;
            slot = base + j;
          end
        end
      end
      if (!hit) begin
        r.status = isst_pkg::RES_MISS;
      end else begin
        r.status   = isst_pkg::RES_OK;
        r.found    = 1'b1;
        r.position = ADDR_W'(slot);
        if (mode == isst_pkg::MODE_DELETE) begin
          for (k = slot; k + 1 < shadow_count; k++)
            shadow_entries[k] = shadow_entries[k + 1];
          shadow_count--;
        end
      end
    end
    r.entry_total = CNT_W'(shadow_count);
    return r;
  endfunction

  // compare result beats, then take config and command beats
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      shadow_count  = 0;
      shadow_window = isst_pkg::WIN_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        n_results++;
        if (out_status == isst_pkg::RES_MISS) n_misses++;
        if (out_status == isst_pkg::RES_FULL) n_rejects++;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", int'(out_status), int'(want.status));
          if (out_found !== want.found)
            report_mismatch("found", int'(out_found), int'(want.found));
          if (out_position !== want.position)
            report_mismatch("position", int'(out_position), int'(want.position));
          if (out_window_index !== want.window_index)
            report_mismatch("window_index", int'(out_window_index),
                            int'(want.window_index));
          if (out_entry_total !== want.entry_total)
            report_mismatch("entry_total", int'(out_entry_total),
                            int'(want.entry_total));
        end
      end
      if (cfg_valid && cfg_ready)
        shadow_window = cfg_window_size;
      if (start && !busy)
        awaited_results.push_back(predict_table_op(in_mode, in_key_value));
    end
    pending      <= awaited_results.size();
    fail_count   <= mismatches;
    results_seen <= n_results;
    misses_seen  <= n_misses;
    rejects_seen <= n_rejects;
  end

endmodule

// File: sim/indexed_sequential_sorted_table_core_test.sv
// top of the sorted table testbench: clock, reset, command and window-size stimulus
// depends on isst_pkg, indexed_sequential_sorted_table_core and sorted_table_checker
module indexed_sequential_sorted_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_W  = isst_pkg::KEY_W;
  localparam int ADDR_W = isst_pkg::ADDR_W;
  localparam int CNT_W  = isst_pkg::CNT_W;
  localparam int WIN_W  = isst_pkg::WIN_W;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam int IDLE_LIMIT = 10000;
  localparam int DRAIN_CYCLES = 50;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_mode;
  logic signed [KEY_W-1:0] in_key_value;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic                    out_found;
  logic [ADDR_W-1:0]       out_position;
  logic signed [WIN_W-1:0] out_window_index;
  logic [CNT_W-1:0]        out_entry_total;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [WIN_W-1:0]        cfg_window_size;

  int pending;
  int fail_count;
  int results_seen;
  int misses_seen;
  int rejects_seen;
  int fill;
  int issued;
  int settings_done;
  int quiet_cycles;
  bit steady;

  indexed_sequential_sorted_table_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_key_value     (in_key_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_position     (out_position),
    .out_window_index (out_window_index),
    .out_entry_total  (out_entry_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_size  (cfg_window_size)
  );

  sorted_table_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_key_value     (in_key_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_position     (out_position),
    .out_window_index (out_window_index),
    .out_entry_total  (out_entry_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_size  (cfg_window_size),
    .pending          (pending),
    .fail_count       (fail_count),
    .results_seen     (results_seen),
    .misses_seen      (misses_seen),
    .rejects_seen     (rejects_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table fill as last reported, used only to steer the operation mix
  always @(posedge clk) begin
    if (!rst_n) fill <= 0;
    else if (out_valid) fill <= int'(out_entry_total);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // small pool for hits and duplicates, extremes, and full-range noise
  function automatic logic signed [KEY_W-1:0] draw_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return $signed($urandom_range(0, 40)) - 32'sd20;
    if (pick < 65) begin
      case ($urandom_range(0, 5))
        0:       return KEY_MIN;
        1:       return KEY_MIN + 32'sd1;
        2:       return KEY_MAX;
        3:       return KEY_MAX - 32'sd1;
        4:       return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // grow below the target fill, shrink above it
  function automatic logic [1:0] pick_mode(input int target);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return MODE_SPARE;
    if (fill < target) begin
      if (pick < 55) return isst_pkg::MODE_INSERT;
      if (pick < 80) return isst_pkg::MODE_DELETE;
      return isst_pkg::MODE_SEARCH;
    end
    if (pick < 25) return isst_pkg::MODE_INSERT;
    if (pick < 75) return isst_pkg::MODE_DELETE;
    return isst_pkg::MODE_SEARCH;
  endfunction

  // one command beat; start is left high for a back-to-back follower
  task automatic issue(input logic [1:0] mode, input logic signed [KEY_W-1:0] key);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 6) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        = 1'b1;
    in_mode      = mode;
    in_key_value = key;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    issued++;
  endtask

  task automatic run_random(input int count, input int target);
    repeat (count) issue(pick_mode(target), draw_key());
  endtask

  // window size change once every result is back
  task automatic set_window(input logic [WIN_W-1:0] span);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 30) @(negedge clk);
    cfg_valid       = 1'b1;
    cfg_window_size = span;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_done++;
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = isst_pkg::MODE_SEARCH;
    in_key_value    = '0;
    cfg_valid       = 1'b0;
    cfg_window_size = isst_pkg::WIN_RESET;
    issued          = 0;
    settings_done   = 0;
    quiet_cycles    = 0;
    steady          = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, extremes, duplicates, key below the first head
    issue(isst_pkg::MODE_SEARCH, '0);
    issue(isst_pkg::MODE_DELETE, 32'sd5);
    issue(MODE_SPARE, -32'sd1);
    issue(isst_pkg::MODE_INSERT, '0);
    issue(isst_pkg::MODE_INSERT, KEY_MAX);
    issue(isst_pkg::MODE_INSERT, KEY_MIN);
    issue(isst_pkg::MODE_INSERT, -32'sd1);
    issue(isst_pkg::MODE_INSERT, 32'sd1);
    repeat (4) issue(isst_pkg::MODE_INSERT, 32'sd7);
    issue(isst_pkg::MODE_SEARCH, 32'sd7);
    issue(isst_pkg::MODE_SEARCH, KEY_MIN);
    issue(isst_pkg::MODE_SEARCH, KEY_MAX);
    issue(isst_pkg::MODE_SEARCH, 32'sd100);
    issue(MODE_SPARE, 32'sd7);
    issue(isst_pkg::MODE_DELETE, 32'sd7);
    issue(isst_pkg::MODE_DELETE, KEY_MIN);
    issue(isst_pkg::MODE_SEARCH, KEY_MIN);
    issue(isst_pkg::MODE_DELETE, 32'sd42);
    issue(isst_pkg::MODE_INSERT, -32'sd5);
    issue(isst_pkg::MODE_SEARCH, -32'sd5);
    issue(isst_pkg::MODE_DELETE, KEY_MAX);

    // random phases over a spread of window sizes
    set_window(WIN_W'(1));
    run_random(80, 12);
    set_window(WIN_W'(2));
    steady = 1'b1;
    run_random(80, 30);
    steady = 1'b0;
    set_window(WIN_W'(3));
    run_random(80, 20);
    set_window('0);
    run_random(60, 10);
    set_window(WIN_W'(7));
    run_random(80, 60);
    set_window(WIN_W'(16));
    run_random(80, 100);

    // fill to capacity with one wide window, then knock on the full store
    set_window(WIN_W'(256));
    steady = 1'b1;
    while (fill < isst_pkg::DEPTH) issue(isst_pkg::MODE_INSERT, draw_key());
    steady = 1'b0;
    repeat (3) issue(isst_pkg::MODE_INSERT, draw_key());
    repeat (5) issue(isst_pkg::MODE_SEARCH, draw_key());

    // window wider than the store, then one slot per head on a near-full store
    set_window(WIN_W'(511));
    run_random(20, isst_pkg::DEPTH);
    set_window(WIN_W'(1));
    run_random(20, isst_pkg::DEPTH);
    set_window(WIN_W'(5));
    run_random(150, 0);
    set_window(isst_pkg::WIN_RESET);
    run_random(30, 150);

    // let the last results come home
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d commands over %0d window settings, store filled to capacity",
             issued, settings_done + 1);
    $display("results %0d: %0d not found, %0d rejected as full, %0d mismatches",
             results_seen, misses_seen, rejects_seen, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
